FILE: src/tv_gradient_stencil_top_defines.svh
// assertion macros shared by the checker of the tv gradient stencil
// expects signals named clk and rst in the scope of each use
`ifndef TV_GRADIENT_STENCIL_TOP_DEFINES_SVH
`define TV_GRADIENT_STENCIL_TOP_DEFINES_SVH

// checked only outside reset
`define TVGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define TVGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tvgs_pkg.sv
// constants, codes and controller command type of the tv gradient stencil
// no dependencies
package tvgs_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int MAX_HEIGHT     = 1024;
  localparam int ROW_BITS       = 10;
  localparam int CFG_BITS       = 11;
  localparam int CFG_IDX_BITS   = 1;
  localparam int GRAD_BITS      = 16;
  localparam int FRAC_OUT       = 12;
  localparam int EPS_SQ         = 4096;
  localparam int MIN_DIM        = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // line store read address relative to the centre column
  localparam logic [1:0] ADDR_CENTER = 2'd0;
  localparam logic [1:0] ADDR_LEFT   = 2'd1;
  localparam logic [1:0] ADDR_RIGHT  = 2'd2;

  // which of the three quotient terms is worked on
  localparam logic [1:0] TERM_CENTER = 2'd0;
  localparam logic [1:0] TERM_LEFT   = 2'd1;
  localparam logic [1:0] TERM_UP     = 2'd2;

  typedef struct packed {
    logic       take_pixel;
    logic [1:0] addr_sel;
    logic       cap_center;
    logic       cap_left;
    logic       cap_right;
    logic       line_write;
    logic       acc_clear;
    logic [1:0] term;
    logic       sq_first;
    logic       sq_second;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       acc_add;
    logic       load_out;
    logic       out_zero;
  } cmd_t;

endpackage

FILE: src/tvgs_if.sv
// stream channel interfaces of the tv gradient stencil: pixels in, gradients out
// depends on tvgs_pkg
interface tvgs_in_if #(
  parameter int PIXEL_BITS = tvgs_pkg::DEF_PIXEL_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output kind, output pixel, input ready);
  modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface tvgs_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tvgs_pkg::GRAD_BITS-1:0]  gradient;
  logic                                   last_in_frame;

  modport source (output valid, output gradient, output last_in_frame, input ready);
  modport sink   (input valid, input gradient, input last_in_frame, output ready);
endinterface

FILE: src/tvgs_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module tvgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tvgs_ctrl.sv
// controller of the tv gradient stencil: configuration, raster counters, sequencing
// depends on tvgs_pkg
module tvgs_ctrl #(
  parameter int MAX_WIDTH  = tvgs_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = tvgs_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [tvgs_pkg::CFG_IDX_BITS-1:0] reg_index,
  input  logic [tvgs_pkg::CFG_BITS-1:0]     write_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_last,
  output logic [$clog2(MAX_WIDTH)-1:0]      column,
  output tvgs_pkg::cmd_t                    cmd
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RB  = tvgs_pkg::ROW_BITS;
  localparam int K   = 31 - PIXEL_BITS;
  localparam int SW  = 2 * PIXEL_BITS + 3;
  localparam int RW  = 2 * ((SW + 2 * K + 1) / 2);
  localparam int RH  = RW / 2;
  localparam int DVW = PIXEL_BITS + 2 + tvgs_pkg::FRAC_OUT + K + 1;
  localparam int CW  = $clog2(DVW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RA    = 4'd1;
  localparam logic [3:0] S_RB    = 4'd2;
  localparam logic [3:0] S_RC    = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_SQA   = 4'd5;
  localparam logic [3:0] S_SQB   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_DINIT = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]                   state;
  logic [tvgs_pkg::CFG_BITS-1:0] cfg_w;
  logic [tvgs_pkg::CFG_BITS-1:0] cfg_h;
  logic [AW-1:0]                in_col;
  logic [RB-1:0]                in_row;
  logic [AW-1:0]                emit_col;
  logic [RB-1:0]                emit_row;
  logic [AW:0]                  pending;
  logic                         emit_f;
  logic                         inter_f;
  logic                         zero_f;
  logic                         last_f;
  logic [1:0]                   term;
  logic [CW-1:0]                cnt;

  logic [AW:0]  eff_w;
  logic [RB:0]  eff_h;
  logic         accept;
  logic         emit_now;
  logic         interior;
  logic         last_now;
  logic         in_col_wrap;
  logic         in_row_wrap;
  logic         emit_col_wrap;
  logic         emit_row_wrap;

  always_comb begin
    if (cfg_w < tvgs_pkg::CFG_BITS'(tvgs_pkg::MIN_DIM)) begin
      eff_w = (AW+1)'(tvgs_pkg::MIN_DIM);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      eff_w = (AW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (AW+1)'(cfg_w);
    end
    if (cfg_h < tvgs_pkg::CFG_BITS'(tvgs_pkg::MIN_DIM)) begin
      eff_h = (RB+1)'(tvgs_pkg::MIN_DIM);
    end else if (32'(cfg_h) > tvgs_pkg::MAX_HEIGHT) begin
      eff_h = (RB+1)'(tvgs_pkg::MAX_HEIGHT);
    end else begin
      eff_h = (RB+1)'(cfg_h);
    end
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;
  assign emit_now = (pending >= eff_w);
  // interior centre: not on the frame border, tested on the emit row and input column
  assign interior = (emit_row != '0) && ((RB+1)'(emit_row) + (RB+1)'(2) <= eff_h) &&
                    (in_col != '0) && ((AW+1)'(in_col) + (AW+1)'(2) <= eff_w);
  assign last_now = ((RB+1)'(emit_row) == eff_h - (RB+1)'(1)) &&
                    ((AW+1)'(emit_col) == eff_w - (AW+1)'(1));

  assign in_col_wrap   = ((AW+1)'(in_col) + (AW+1)'(1) >= eff_w);
  assign in_row_wrap   = ((RB+1)'(in_row) + (RB+1)'(1) >= eff_h);
  assign emit_col_wrap = ((AW+1)'(emit_col) + (AW+1)'(1) >= eff_w);
  assign emit_row_wrap = ((RB+1)'(emit_row) + (RB+1)'(1) >= eff_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cfg_w     <= tvgs_pkg::CFG_BITS'(1024);
      cfg_h     <= tvgs_pkg::CFG_BITS'(1024);
      in_col    <= '0;
      in_row    <= '0;
      emit_col  <= '0;
      emit_row  <= '0;
      pending   <= '0;
      emit_f    <= 1'b0;
      inter_f   <= 1'b0;
      zero_f    <= 1'b0;
      last_f    <= 1'b0;
      term      <= tvgs_pkg::TERM_CENTER;
      cnt       <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
      column    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_kind == tvgs_pkg::KIND_FLUSH) begin
              if (pending != '0) begin
                last_f  <= last_now;
                zero_f  <= 1'b1;
                pending <= pending - (AW+1)'(1);
                if (emit_col_wrap) begin
                  emit_col <= '0;
                  emit_row <= emit_row_wrap ? '0 : emit_row + RB'(1);
                end else begin
                  emit_col <= emit_col + AW'(1);
                end
                state <= S_OUT;
              end
            end else begin
              column  <= in_col;
              emit_f  <= emit_now;
              inter_f <= interior;
              zero_f  <= !interior;
              last_f  <= last_now;
              if (emit_now) begin
                if (emit_col_wrap) begin
                  emit_col <= '0;
                  emit_row <= emit_row_wrap ? '0 : emit_row + RB'(1);
                end else begin
                  emit_col <= emit_col + AW'(1);
                end
              end else begin
                pending <= pending + (AW+1)'(1);
              end
              if (in_col_wrap) begin
                in_col <= '0;
                in_row <= in_row_wrap ? '0 : in_row + RB'(1);
              end else begin
                in_col <= in_col + AW'(1);
              end
              state <= S_RA;
            end
          end
        end
        S_RA: state <= S_RB;
        S_RB: state <= S_RC;
        S_RC: state <= S_RD;
        S_RD: begin
          if (emit_f && inter_f) begin
            term  <= tvgs_pkg::TERM_CENTER;
            state <= S_SQA;
          end else if (emit_f) begin
            state <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQA: state <= S_SQB;
        S_SQB: begin
          cnt   <= CW'(RH - 1);
          state <= S_SQRT;
        end
        S_SQRT: begin
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= S_DINIT;
          end
        end
        S_DINIT: begin
          cnt   <= CW'(DVW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt - CW'(1);
          if (cnt == '0) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (term == tvgs_pkg::TERM_UP) begin
            state <= S_OUT;
          end else begin
            term  <= term + 2'd1;
            state <= S_SQA;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_last  <= last_f;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // a register write restarts the stream, line stores keep their contents
      if (write_enable) begin
        if (reg_index == tvgs_pkg::REG_IMAGE_WIDTH) begin
          cfg_w <= write_data;
        end else begin
          cfg_h <= write_data;
        end
        in_col   <= '0;
        in_row   <= '0;
        emit_col <= '0;
        emit_row <= '0;
        pending  <= '0;
      end
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.take_pixel = accept && (in_kind == tvgs_pkg::KIND_PIXEL);
    cmd.term       = term;
    cmd.out_zero   = zero_f;
    case (state)
      S_RA:    cmd.addr_sel = tvgs_pkg::ADDR_CENTER;
      S_RB: begin
        cmd.addr_sel   = tvgs_pkg::ADDR_LEFT;
        cmd.cap_center = 1'b1;
      end
      S_RC: begin
        cmd.addr_sel = tvgs_pkg::ADDR_RIGHT;
        cmd.cap_left = 1'b1;
      end
      S_RD: begin
        cmd.cap_right  = 1'b1;
        cmd.line_write = 1'b1;
        cmd.acc_clear  = 1'b1;
      end
      S_SQA:   cmd.sq_first  = 1'b1;
      S_SQB:   cmd.sq_second = 1'b1;
      S_SQRT:  cmd.sqrt_step = 1'b1;
      S_DINIT: cmd.div_init  = 1'b1;
      S_DIV:   cmd.div_step  = 1'b1;
      S_ACC:   cmd.acc_add   = 1'b1;
      S_OUT:   cmd.load_out  = 1'b1;
      default: cmd.addr_sel  = tvgs_pkg::ADDR_CENTER;
    endcase
  end

endmodule

FILE: src/tvgs_datapath.sv
// datapath of the tv gradient stencil: line stores, window, square, root, divide, sum
// depends on tvgs_pkg and tvgs_ram
module tvgs_datapath #(
  parameter int MAX_WIDTH  = tvgs_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = tvgs_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic signed [PIXEL_BITS-1:0]          pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0]          column,
  input  tvgs_pkg::cmd_t                        cmd,
  output logic signed [tvgs_pkg::GRAD_BITS-1:0] gradient
);

  localparam int P   = PIXEL_BITS;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int K   = 31 - P;
  localparam int SW  = 2 * P + 3;
  localparam int RW  = 2 * ((SW + 2 * K + 1) / 2);
  localparam int RH  = RW / 2;
  localparam int DVW = P + 2 + tvgs_pkg::FRAC_OUT + K + 1;
  localparam int AC  = DVW + 2;
  localparam int GB  = tvgs_pkg::GRAD_BITS;
  localparam logic signed [AC-1:0] SAT_HI = AC'((1 << (GB - 1)) - 1);
  localparam logic signed [AC-1:0] SAT_LO = -AC'(1 << (GB - 1));

  logic signed [P-1:0] px;
  logic signed [P-1:0] cv, uv, lv, dlv, rv, urv;
  logic [P-1:0]        mid_rd, up_rd;
  logic [AW-1:0]       raddr;
  logic [P:0]          bm;
  logic [P+2:0]        nmag;
  logic                nneg;
  logic [SW-1:0]       sq_acc;
  logic [RW-1:0]       rad;
  logic [RH+2:0]       rem;
  logic [RH-1:0]       root;
  logic [DVW-1:0]      dvd;
  logic [RH-1:0]       drem;
  logic signed [AC-1:0] acc;

  logic signed [P+2:0] num;
  logic signed [P:0]   da, db;
  logic [P:0]          am, bm_now, mul_in;
  logic [2*P+1:0]      prod;
  logic [RH+2:0]       rem_sh, trial;
  logic [RH:0]         dsh;
  logic signed [AC-1:0] q;

  always_comb begin
    case (cmd.addr_sel)
      tvgs_pkg::ADDR_LEFT:  raddr = column - AW'(1);
      tvgs_pkg::ADDR_RIGHT: raddr = column + AW'(1);
      default:              raddr = column;
    endcase
  end

  tvgs_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk   (clk),
    .we    (cmd.line_write),
    .waddr (column),
    .wdata (px),
    .raddr (raddr),
    .rdata (mid_rd)
  );

  tvgs_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_up_ram (
    .clk   (clk),
    .we    (cmd.line_write),
    .waddr (column),
    .wdata (cv),
    .raddr (raddr),
    .rdata (up_rd)
  );

  // operands of the term being worked on; the incoming pixel is the one below
  always_comb begin
    case (cmd.term)
      tvgs_pkg::TERM_LEFT: begin
        num = (P+3)'(cv) - (P+3)'(lv);
        da  = (P+1)'(cv) - (P+1)'(lv);
        db  = (P+1)'(dlv) - (P+1)'(lv);
      end
      tvgs_pkg::TERM_UP: begin
        num = (P+3)'(cv) - (P+3)'(uv);
        da  = (P+1)'(cv) - (P+1)'(uv);
        db  = (P+1)'(urv) - (P+1)'(uv);
      end
      default: begin
        num = ((P+3)'(cv) <<< 1) - (P+3)'(rv) - (P+3)'(px);
        da  = (P+1)'(rv) - (P+1)'(cv);
        db  = (P+1)'(px) - (P+1)'(cv);
      end
    endcase
    am     = da[P] ? (P+1)'(-da) : (P+1)'(da);
    bm_now = db[P] ? (P+1)'(-db) : (P+1)'(db);
    mul_in = cmd.sq_first ? am : bm;
    prod   = mul_in * mul_in;
    rem_sh = {rem[RH:0], rad[RW-1:RW-2]};
    trial  = {1'b0, root, 2'b01};
    dsh    = {drem, dvd[DVW-1]};
    q      = nneg ? -signed'({2'b00, dvd}) : signed'({2'b00, dvd});
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      px <= pixel;
    end
    if (cmd.cap_center) begin
      cv <= mid_rd;
      uv <= up_rd;
    end
    if (cmd.cap_left) begin
      dlv <= mid_rd;
      lv  <= up_rd;
    end
    if (cmd.cap_right) begin
      rv  <= mid_rd;
      urv <= up_rd;
    end
    if (cmd.sq_first) begin
      sq_acc <= SW'(prod) + SW'(tvgs_pkg::EPS_SQ);
      bm     <= bm_now;
      nneg   <= num[P+2];
      nmag   <= num[P+2] ? (P+3)'(-num) : (P+3)'(num);
    end
    if (cmd.sq_second) begin
      rad  <= RW'(sq_acc + SW'(prod)) << (2 * K);
      rem  <= '0;
      root <= '0;
    end
    // square root, two radicand bits per step
    if (cmd.sqrt_step) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RH-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RH-2:0], 1'b0};
      end
    end
    // rounded quotient: half the divisor added before a restoring division
    if (cmd.div_init) begin
      dvd  <= (DVW'(nmag) << (tvgs_pkg::FRAC_OUT + K)) + DVW'(root[RH-1:1]);
      drem <= '0;
    end
    if (cmd.div_step) begin
      if (dsh >= {1'b0, root}) begin
        drem <= RH'(dsh - {1'b0, root});
        dvd  <= {dvd[DVW-2:0], 1'b1};
      end else begin
        drem <= RH'(dsh);
        dvd  <= {dvd[DVW-2:0], 1'b0};
      end
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_add) begin
      acc <= acc + q;
    end
    if (cmd.load_out) begin
      if (cmd.out_zero) begin
        gradient <= '0;
      end else if (acc > SAT_HI) begin
        gradient <= GB'(SAT_HI);
      end else if (acc < SAT_LO) begin
        gradient <= GB'(SAT_LO);
      end else begin
        gradient <= GB'(acc);
      end
    end
  end

endmodule

FILE: src/tv_gradient_stencil_top.sv
// top level of the tv gradient stencil: isotropic total variation gradient of a pixel stream
// depends on tvgs_pkg, tvgs_if, tvgs_ctrl, tvgs_datapath
//
// channel   dir  payload                          transfer
// pixels    in   kind, pixel (Q9.6)               valid & ready
// results   out  gradient (Q3.12), last_in_frame  valid & ready
// config    in   reg_index, write_data            write_enable
//
// a pixel reads the line stores in states RA to RD and writes the new pixel back in RD
// an interior result adds three terms, each with two squares on one multiplier,
// a 33-step square root and a 46-step restoring divide; a border result skips them
// a new item waits until the output register is empty
// synchronous reset clears counters and sets both dimensions to 1024, line stores need no clearing
module tv_gradient_stencil_top #(
  parameter int MAX_WIDTH  = tvgs_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = tvgs_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [tvgs_pkg::CFG_IDX_BITS-1:0] reg_index,
  input  logic [tvgs_pkg::CFG_BITS-1:0]     write_data,
  tvgs_in_if.sink                           pixels,
  tvgs_out_if.source                        results
);

  logic [$clog2(MAX_WIDTH)-1:0] column;
  tvgs_pkg::cmd_t               cmd;

  tvgs_ctrl #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .in_valid     (pixels.valid),
    .in_ready     (pixels.ready),
    .in_kind      (pixels.kind),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_last     (results.last_in_frame),
    .column       (column),
    .cmd          (cmd)
  );

  tvgs_datapath #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_datapath (
    .clk      (clk),
    .pixel    (pixels.pixel),
    .column   (column),
    .cmd      (cmd),
    .gradient (results.gradient)
  );

endmodule

FILE: src/tvgs_checker.sv
// port level checker of the tv gradient stencil, bound to the top level
// depends on tvgs_pkg and tv_gradient_stencil_top_defines.svh
`include "tv_gradient_stencil_top_defines.svh"

module tvgs_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  in_kind,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [tvgs_pkg::GRAD_BITS-1:0] gradient,
  input logic                                  last_in_frame
);

  // a stalled result keeps its payload
  `TVGS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(gradient) && $stable(last_in_frame), "stalled result changed")

  // no item is taken while a result waits in the output register
  `TVGS_ASSERT(a_busy_out, out_valid |-> !in_ready, "input ready while result waits")

  // a pixel transfer always starts line store work
  `TVGS_ASSERT(a_pixel_busy, in_valid && in_ready && (in_kind == tvgs_pkg::KIND_PIXEL) |=> !in_ready, "ready right after pixel")

  // reset leaves no result pending
  `TVGS_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind tv_gradient_stencil_top tvgs_checker u_tvgs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixels.valid),
  .in_ready      (pixels.ready),
  .in_kind       (pixels.kind),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .gradient      (results.gradient),
  .last_in_frame (results.last_in_frame)
);
